@@ src/uart_16550_register_model_macros.svh @@
// Assertion macros for the UART register model checker.
`ifndef UART_16550_REGISTER_MODEL_MACROS_SVH
`define UART_16550_REGISTER_MODEL_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define U16550_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u16550 check failed");

// Next-cycle implication, sampled on clk, masked during reset.
`define U16550_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u16550 check failed");

`endif

@@ src/u16550_pkg.sv @@
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types and constants for the 16550-style UART register model.
// ----------------------------------------------------------------------------
package u16550_pkg;

	localparam int TX_FIFO_DEPTH = 16;
	localparam int RX_FIFO_DEPTH = 14;

	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_RXBYTE = 2'd2;
	localparam logic [1:0] ACT_TXSLOT = 2'd3;

	localparam logic [2:0] REG_DATA = 3'd0;
	localparam logic [2:0] REG_IER  = 3'd1;
	localparam logic [2:0] REG_IIR  = 3'd2;
	localparam logic [2:0] REG_LCR  = 3'd3;
	localparam logic [2:0] REG_MCR  = 3'd4;
	localparam logic [2:0] REG_LSR  = 3'd5;
	localparam logic [2:0] REG_MSR  = 3'd6;
	localparam logic [2:0] REG_SCR  = 3'd7;

	localparam logic [1:0] VAR_8250  = 2'd0;
	localparam logic [1:0] VAR_8250J = 2'd1;
	localparam logic [1:0] VAR_16450 = 2'd2;
	localparam logic [1:0] VAR_16550 = 2'd3;

	// pending interrupt bit positions
	localparam int PI_LSR = 0;
	localparam int PI_RX  = 1;
	localparam int PI_TX  = 2;
	localparam int PI_MSR = 3;

	localparam logic [2:0] IIR_NONE = 3'd1;
	localparam logic [2:0] IIR_LSR  = 3'd6;
	localparam logic [2:0] IIR_RX   = 3'd4;
	localparam logic [2:0] IIR_TX   = 3'd2;
	localparam logic [2:0] IIR_MSR  = 3'd0;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] reg_addr;
		logic [7:0] data_in;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_active;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_start;
		logic       rts_rise;
	} result_t;

	// write/clear requests from the register logic to one queue memory
	typedef struct packed {
		logic       wr_en;
		logic [3:0] wr_addr;
		logic [7:0] wr_data;
		logic       clr;
	} qctl_t;

endpackage

@@ src/u16550_queue.sv @@
// ----------------------------------------------------------------------------
// u16550_queue
// Byte queue memory: one registered read, one write, per-entry valid bits.
// ----------------------------------------------------------------------------
module u16550_queue #(
	parameter int DEPTH = u16550_pkg::TX_FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          rd_addr,
	output logic [7:0]          rd_data,
	input  u16550_pkg::qctl_t   ctl
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_q;
	logic             rd_vld_q;
	logic             rd_ok;

	assign rd_ok = ({28'd0, rd_addr} < DEPTH);

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ({28'd0, ctl.wr_addr} < DEPTH)) begin
			mem[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
		end
		rd_q <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_ok && vld_q[rd_addr[AW-1:0]];
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en && ({28'd0, ctl.wr_addr} < DEPTH)) begin
				vld_q[ctl.wr_addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	// never-written or cleared entries read as zero
	assign rd_data = rd_vld_q ? rd_q : 8'd0;

endmodule

@@ src/u16550_core.sv @@
// ----------------------------------------------------------------------------
// u16550_core
// Register file and update logic; commits one item per commit pulse.
// ----------------------------------------------------------------------------
module u16550_core #(
	parameter int TX_DEPTH = u16550_pkg::TX_FIFO_DEPTH,
	parameter int RX_DEPTH = u16550_pkg::RX_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_data,
	input  logic                  commit,
	input  u16550_pkg::item_t     item_s1,
	input  logic [7:0]            tx_rd,
	input  logic [7:0]            rx_rd,
	output logic [3:0]            tx_pos,
	output logic [3:0]            rx_pos,
	output u16550_pkg::qctl_t     tx_ctl,
	output u16550_pkg::qctl_t     rx_ctl,
	output u16550_pkg::result_t   res
);

	logic [1:0]  variant_q;
	logic [15:0] div_q;
	logic [3:0]  ier_q, pend_q, trig_q, txp_q, rxp_q;
	logic [2:0]  iir_q;
	logic [7:0]  fcr_q, lcr_q, mcr_q, lsr_q, msr_q, rxh_q, txh_q, scr_q;
	logic        fon_q, busy_q, lvl_q;

	logic [15:0] n_div;
	logic [3:0]  n_ier, n_pend, n_trig, n_txp, n_rxp;
	logic [2:0]  n_iir;
	logic [7:0]  n_fcr, n_lcr, n_mcr, n_lsr, n_msr, n_rxh, n_txh, n_scr;
	logic        n_fon, n_busy, n_lvl;

	function automatic logic [3:0] mod_len(input logic [4:0] v, input logic [3:0] len);
		logic [4:0] t;
		t = v - 5'd14;
		unique case (len)
			4'd4:    mod_len = {2'b00, v[1:0]};
			4'd8:    mod_len = {1'b0, v[2:0]};
			4'd14:   mod_len = (v >= 5'd14) ? t[3:0] : v[3:0];
			default: mod_len = 4'd0;
		endcase
	endfunction

	assign tx_pos = txp_q;
	assign rx_pos = rxp_q;

	always_comb begin
		logic       qm, ev, req, rx_do, spd, stx;
		logic [7:0] rx_b, rd, v, old, nm;
		logic       rts, txv, txs;
		logic [7:0] txb;
		logic [3:0] len;
		n_div = div_q; n_ier = ier_q; n_pend = pend_q; n_trig = trig_q;
		n_txp = txp_q; n_rxp = rxp_q; n_iir = iir_q; n_fcr = fcr_q;
		n_lcr = lcr_q; n_mcr = mcr_q; n_lsr = lsr_q; n_msr = msr_q;
		n_rxh = rxh_q; n_txh = txh_q; n_scr = scr_q; n_fon = fon_q;
		n_busy = busy_q; n_lvl = lvl_q;
		tx_ctl = '0; rx_ctl = '0;
		ev = 1'b0; req = 1'b0; rx_do = 1'b0; rx_b = 8'd0; spd = 1'b0; stx = 1'b0;
		rd = 8'd0; rts = 1'b0; txv = 1'b0; txb = 8'd0; txs = 1'b0;
		v = item_s1.data_in; old = 8'd0; nm = 8'd0;
		qm = (variant_q == u16550_pkg::VAR_16550) && fon_q;
		len = (trig_q == 4'd0) ? 4'd1 : trig_q;

		unique case (item_s1.action)
			u16550_pkg::ACT_READ: begin
				unique case (item_s1.reg_addr)
					u16550_pkg::REG_DATA: begin
						if (lcr_q[7]) begin
							rd = div_q[7:0];
						end else if (qm) begin
							if (mcr_q[4]) begin
								rd = ({28'd0, txp_q} < TX_DEPTH) ? tx_rd : 8'd0;
								n_txp = txp_q + 4'd1;
								if (n_txp == 4'd0) begin
									n_lsr[0] = 1'b0; n_pend[u16550_pkg::PI_RX] = 1'b0; ev = 1'b1;
								end
							end else begin
								rd = ({28'd0, rxp_q} < RX_DEPTH) ? rx_rd : 8'd0;
								n_rxp = mod_len({1'b0, rxp_q} + 5'd1, len);
								if (n_rxp == 4'd0) begin
									n_lsr[0] = 1'b0; n_pend[u16550_pkg::PI_RX] = 1'b0; ev = 1'b1;
								end
							end
						end else begin
							rd = rxh_q;
							n_lsr[0] = 1'b0; n_pend[u16550_pkg::PI_RX] = 1'b0; ev = 1'b1;
						end
					end
					u16550_pkg::REG_IER: rd = lcr_q[7] ? div_q[15:8] : {4'd0, ier_q};
					u16550_pkg::REG_IIR: begin
						rd = {5'd0, iir_q};
						if (iir_q[2:1] == 2'b01) begin
							n_pend[u16550_pkg::PI_TX] = 1'b0; ev = 1'b1;
						end
						if (fcr_q[0]) rd[7:6] = 2'b11;
					end
					u16550_pkg::REG_LCR: rd = lcr_q;
					u16550_pkg::REG_MCR: rd = mcr_q;
					u16550_pkg::REG_LSR: begin
						n_lsr = lsr_q;
						if (lsr_q[5]) n_lsr[6] = 1'b1;
						n_lsr[5] = 1'b1;
						rd = n_lsr;
						if (n_lsr[4:0] != 5'd0) n_lsr[4:1] = 4'd0;
						n_pend[u16550_pkg::PI_LSR] = 1'b0; ev = 1'b1;
					end
					u16550_pkg::REG_MSR: begin
						rd = msr_q;
						n_msr = {msr_q[7:4], 4'd0};
						n_pend[u16550_pkg::PI_MSR] = 1'b0; ev = 1'b1;
					end
					default: rd = scr_q;
				endcase
			end
			u16550_pkg::ACT_WRITE: begin
				unique case (item_s1.reg_addr)
					u16550_pkg::REG_DATA: begin
						if (lcr_q[7]) begin
							n_div[7:0] = v; spd = 1'b1;
						end else if (qm) begin
							tx_ctl.wr_en = 1'b1; tx_ctl.wr_addr = txp_q; tx_ctl.wr_data = v;
							n_txp = txp_q + 4'd1;
							if (n_txp != 4'd0) begin
								old = lsr_q;
								n_lsr = lsr_q & 8'h9f;
								if (old[5]) ev = 1'b1;
							end else begin
								stx = 1'b1;
							end
						end else begin
							n_txh = v; stx = 1'b1;
						end
					end
					u16550_pkg::REG_IER: begin
						if (lcr_q[7]) begin
							n_div[15:8] = v; spd = 1'b1;
						end else begin
							n_ier = v[3:0]; ev = 1'b1;
						end
					end
					u16550_pkg::REG_IIR: begin
						if (variant_q == u16550_pkg::VAR_16550) begin
							n_fcr = v & 8'hf9;
							n_fon = v[0];
							if (!v[0]) begin
								tx_ctl.clr = 1'b1; rx_ctl.clr = 1'b1;
								n_rxp = 4'd0; n_txp = 4'd0; n_trig = 4'd1;
							end else begin
								if (v[1]) begin
									rx_ctl.clr = 1'b1; n_rxp = 4'd0;
								end
								if (v[2]) begin
									tx_ctl.clr = 1'b1; n_txp = 4'd0;
								end
								unique case (v[7:6])
									2'd0: n_trig = 4'd1;
									2'd1: n_trig = 4'd4;
									2'd2: n_trig = 4'd8;
									default: n_trig = 4'd14;
								endcase
							end
						end
					end
					u16550_pkg::REG_LCR: begin
						if ((lcr_q[3:0] ^ v[3:0]) != 4'd0) spd = 1'b1;
						n_lcr = v;
					end
					u16550_pkg::REG_MCR: begin
						rts = v[1] && !mcr_q[1];
						n_mcr = v;
						if (v[4]) begin
							nm = {v[3:2], v[0], v[1], 4'd0};
							nm[0] = msr_q[4] ^ nm[4];
							nm[1] = msr_q[5] ^ nm[5];
							nm[3] = msr_q[7] ^ nm[7];
							nm[2] = msr_q[6] && !nm[6];
							n_msr = nm;
							n_txp = 4'd0; n_rxp = 4'd0;
						end
					end
					u16550_pkg::REG_LSR: begin
						n_lsr = v;
						if (v[0]) n_pend[u16550_pkg::PI_RX] = 1'b1;
						if (v[4:1] != 4'd0) n_pend[u16550_pkg::PI_LSR] = 1'b1;
						if (v[5]) n_pend[u16550_pkg::PI_TX] = 1'b1;
						ev = 1'b1;
					end
					u16550_pkg::REG_MSR: begin
						n_msr = v;
						if (v[3:0] != 4'd0) n_pend[u16550_pkg::PI_MSR] = 1'b1;
						ev = 1'b1;
					end
					default: begin
						if (variant_q >= u16550_pkg::VAR_16450) n_scr = v;
					end
				endcase
			end
			u16550_pkg::ACT_RXBYTE: begin
				rx_do = 1'b1; rx_b = v;
			end
			default: begin
				if (busy_q) begin
					if (fon_q) begin
						n_txp = txp_q + 4'd1;
						if (mcr_q[4]) begin
							rx_do = 1'b1; rx_b = tx_rd;
						end else begin
							txv = 1'b1; txb = tx_rd;
						end
						if (n_txp == 4'd0) begin
							n_lsr[6] = 1'b1; n_busy = 1'b0;
						end
					end else begin
						if (mcr_q[4]) begin
							rx_do = 1'b1; rx_b = txh_q;
						end else begin
							txv = 1'b1; txb = txh_q;
						end
						n_lsr[6] = 1'b1; n_busy = 1'b0;
					end
				end
			end
		endcase

		if (spd && busy_q) txs = 1'b1;
		if (stx) begin
			txs = 1'b1; n_busy = 1'b1;
			n_lsr[6] = 1'b0; n_lsr[5] = 1'b1;
			n_pend[u16550_pkg::PI_TX] = 1'b1; ev = 1'b1;
		end

		// receive path: line byte or loopback of a sent byte
		if (rx_do) begin
			if (qm) begin
				rx_ctl.wr_en = 1'b1; rx_ctl.wr_addr = rxp_q; rx_ctl.wr_data = rx_b;
				n_rxp = mod_len({1'b0, rxp_q} + 5'd1, len);
				n_lsr[0] = (n_rxp == 4'd0);
				n_pend[u16550_pkg::PI_RX] = (n_rxp == 4'd0);
				if (n_rxp == 4'd0) ev = 1'b1;
			end else begin
				n_rxh = rx_b; n_lsr[0] = 1'b1;
				n_pend[u16550_pkg::PI_RX] = 1'b1; ev = 1'b1;
			end
		end

		// evaluation only ever runs on the item's final masks
		if (ev) begin
			req = 1'b1;
			priority if (n_ier[2] && n_pend[u16550_pkg::PI_LSR]) n_iir = u16550_pkg::IIR_LSR;
			else if (n_ier[0] && n_pend[u16550_pkg::PI_RX]) n_iir = u16550_pkg::IIR_RX;
			else if (n_ier[1] && n_pend[u16550_pkg::PI_TX]) n_iir = u16550_pkg::IIR_TX;
			else if (n_ier[3] && n_pend[u16550_pkg::PI_MSR]) n_iir = u16550_pkg::IIR_MSR;
			else begin
				n_iir = u16550_pkg::IIR_NONE; req = 1'b0;
			end
			req = req && (n_mcr[3] || variant_q == u16550_pkg::VAR_8250J);
			n_lvl = req;
		end

		res.read_data  = rd;
		res.irq_active = (variant_q >= u16550_pkg::VAR_16450) ? n_lvl : (ev && req);
		res.tx_valid   = txv;
		res.tx_byte    = txb;
		res.tx_start   = txs;
		res.rts_rise   = rts;
		if (!commit) begin
			tx_ctl = '0; rx_ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= u16550_pkg::VAR_8250;
			div_q <= 16'd96; ier_q <= '0; pend_q <= '0; trig_q <= 4'd1;
			txp_q <= '0; rxp_q <= '0; iir_q <= '0; fcr_q <= 8'h06;
			lcr_q <= '0; mcr_q <= '0; lsr_q <= '0; msr_q <= '0;
			rxh_q <= '0; txh_q <= '0; scr_q <= '0; fon_q <= 1'b0;
			busy_q <= 1'b0; lvl_q <= 1'b0;
		end else begin
			if (cfg_we) variant_q <= cfg_data;
			if (commit) begin
				div_q <= n_div; ier_q <= n_ier; pend_q <= n_pend; trig_q <= n_trig;
				txp_q <= n_txp; rxp_q <= n_rxp; iir_q <= n_iir; fcr_q <= n_fcr;
				lcr_q <= n_lcr; mcr_q <= n_mcr; lsr_q <= n_lsr; msr_q <= n_msr;
				rxh_q <= n_rxh; txh_q <= n_txh; scr_q <= n_scr; fon_q <= n_fon;
				busy_q <= n_busy; lvl_q <= n_lvl;
			end
		end
	end

endmodule

@@ src/uart_16550_register_model.sv @@
// ----------------------------------------------------------------------------
// uart_16550_register_model
// 8250/16450/16550 UART register file with transmit and receive queues.
// ----------------------------------------------------------------------------
//  channel   signals                       beat taken when
//  -------   ---------------------------   ------------------------------
//  config    cfg_valid cfg_ready cfg_data  cfg_valid && cfg_ready
//  item in   start busy item               start && !busy
//  result    done result                   every cycle done is high
//
// The accept edge issues the queue memory reads at the current queue positions;
// the next edge commits the register update and queue write and registers the
// result. No new item is taken while busy is high, so the block cannot take
// a new item before it has committed the last one.
// Reset clears core state, handshake flags and queue valid bits at once; no sweep.
// The result strobe lasts one cycle; the receiver cannot stall it.
module uart_16550_register_model #(
	parameter int TX_FIFO_DEPTH = u16550_pkg::TX_FIFO_DEPTH,
	parameter int RX_FIFO_DEPTH = u16550_pkg::RX_FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  u16550_pkg::item_t    item,
	output logic                 done,
	output u16550_pkg::result_t  result
);

	u16550_pkg::item_t   item_s1;
	u16550_pkg::result_t res;
	u16550_pkg::result_t result_q;
	u16550_pkg::qctl_t   tx_ctl, rx_ctl;
	logic                busy_q, done_q;
	logic [3:0]          tx_pos, rx_pos;
	logic [7:0]          tx_rd, rx_rd;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;
	assign done      = done_q;
	assign result    = result_q;

	// item register: stage 1 holds the beat while the queue reads complete
	always_ff @(posedge clk) begin
		if (start && !busy_q) item_s1 <= item;
		if (busy_q) result_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start && !busy_q;
			done_q <= busy_q;
		end
	end

	// transmit queue, read at tx_pos for drain and loopback reads
	u16550_queue #(.DEPTH(TX_FIFO_DEPTH)) u_txq (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (tx_pos),
		.rd_data (tx_rd),
		.ctl     (tx_ctl)
	);

	// receive queue, read at rx_pos for data port reads
	u16550_queue #(.DEPTH(RX_FIFO_DEPTH)) u_rxq (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rx_pos),
		.rd_data (rx_rd),
		.ctl     (rx_ctl)
	);

	u16550_core #(.TX_DEPTH(TX_FIFO_DEPTH), .RX_DEPTH(RX_FIFO_DEPTH)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.commit   (busy_q),
		.item_s1  (item_s1),
		.tx_rd    (tx_rd),
		.rx_rd    (rx_rd),
		.tx_pos   (tx_pos),
		.rx_pos   (rx_pos),
		.tx_ctl   (tx_ctl),
		.rx_ctl   (rx_ctl),
		.res      (res)
	);

endmodule

@@ src/u16550_checker.sv @@
// ----------------------------------------------------------------------------
// u16550_checker
// Port-level checks on the item and result timing of the register model.
// ----------------------------------------------------------------------------
`include "uart_16550_register_model_macros.svh"

module u16550_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	// an accepted beat makes the block busy in the next cycle
	`U16550_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// a busy cycle always ends in exactly one result
	`U16550_ASSERT_NEXT(a_busy_done, busy, done && !busy)
	// results never come back to back
	`U16550_ASSERT_NEXT(a_done_single, done, !done)
	// config is always taken
	`U16550_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind uart_16550_register_model u16550_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);

@@ dv/uart_16550_register_model_tb.sv @@
// ----------------------------------------------------------------------------
// uart_16550_register_model_tb
// Self-checking bench for the UART register file: directed table of register
// and line beats, then weighted random traffic over every part variant, with
// each result compared against an in-bench model or the table's expected value.
// ----------------------------------------------------------------------------
module uart_16550_register_model_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	u16550_pkg::item_t item = '0;
	logic done;
	u16550_pkg::result_t result;

	uart_16550_register_model DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.start(start), .busy(busy), .item(item),
		.done(done), .result(result)
	);

	always #4 clk = ~clk;

	// hard stop, far beyond any correct run
	initial begin
		#200us;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the register file
	// ------------------------------------------------------------------
	logic [1:0]  m_variant;
	logic [15:0] m_div;
	logic [3:0]  m_ier;
	logic [2:0]  m_iir;
	logic [7:0]  m_fcr;
	logic        m_fifo_on;
	logic [7:0]  m_lcr, m_mcr, m_lsr, m_msr;
	logic [3:0]  m_pend;
	logic [7:0]  m_rbr, m_thr, m_scr;
	logic [7:0]  m_txq [u16550_pkg::TX_FIFO_DEPTH];
	logic [7:0]  m_rxq [u16550_pkg::RX_FIFO_DEPTH];
	int          m_txp, m_rxp, m_trig;
	logic        m_txbusy, m_irq_lvl;
	logic        m_evald, m_ereq;
	u16550_pkg::result_t m_out;

	function automatic void model_reset();
		m_variant = u16550_pkg::VAR_8250; m_div = 16'd96; m_ier = '0; m_iir = '0;
		m_fcr = 8'h06; m_fifo_on = 1'b0; m_lcr = '0; m_mcr = '0; m_lsr = '0;
		m_msr = '0; m_pend = '0; m_rbr = '0; m_thr = '0; m_scr = '0;
		foreach (m_txq[i]) m_txq[i] = '0;
		foreach (m_rxq[i]) m_rxq[i] = '0;
		m_txp = 0; m_rxp = 0; m_trig = 1; m_txbusy = 1'b0; m_irq_lvl = 1'b0;
	endfunction

	// priority LSR > RX > TX > MSR, gated by OUT2 except on the jr part
	function automatic void rank_ints();
		logic hit;
		hit = 1'b1;
		m_iir = u16550_pkg::IIR_NONE;
		if (m_ier[2] && m_pend[u16550_pkg::PI_LSR])      m_iir = u16550_pkg::IIR_LSR;
		else if (m_ier[0] && m_pend[u16550_pkg::PI_RX])  m_iir = u16550_pkg::IIR_RX;
		else if (m_ier[1] && m_pend[u16550_pkg::PI_TX])  m_iir = u16550_pkg::IIR_TX;
		else if (m_ier[3] && m_pend[u16550_pkg::PI_MSR]) m_iir = u16550_pkg::IIR_MSR;
		else hit = 1'b0;
		m_ereq = hit && (m_mcr[3] || m_variant == u16550_pkg::VAR_8250J);
		m_evald = 1'b1;
		m_irq_lvl = m_ereq;
	endfunction

	function automatic logic fifo_mode();
		return m_variant == u16550_pkg::VAR_16550 && m_fifo_on;
	endfunction

	function automatic void line_rx(logic [7:0] b);
		if (fifo_mode()) begin
			if (m_rxp < u16550_pkg::RX_FIFO_DEPTH) m_rxq[m_rxp] = b;
			m_rxp = (m_rxp + 1) % ((m_trig != 0) ? m_trig : 1);
			m_lsr[0] = (m_rxp == 0);
			m_pend[u16550_pkg::PI_RX] = 1'b0;
			if (m_rxp == 0) begin
				m_pend[u16550_pkg::PI_RX] = 1'b1;
				rank_ints();
			end
		end else begin
			m_rbr = b;
			m_lsr[0] = 1'b1;
			m_pend[u16550_pkg::PI_RX] = 1'b1;
			rank_ints();
		end
	endfunction

	function automatic void line_tx(logic [7:0] b);
		if (m_mcr[4]) line_rx(b);
		else begin
			m_out.tx_valid = 1'b1;
			m_out.tx_byte = b;
		end
	endfunction

	function automatic void kick_tx();
		m_out.tx_start = 1'b1;
		m_txbusy = 1'b1;
		m_lsr[6] = 1'b0;
		m_lsr[5] = 1'b1;
		m_pend[u16550_pkg::PI_TX] = 1'b1;
		rank_ints();
	endfunction

	function automatic void reg_write(logic [2:0] a, logic [7:0] v);
		logic [7:0] prev;
		case (a)
			u16550_pkg::REG_DATA: begin
				if (m_lcr[7]) begin
					m_div[7:0] = v;
					if (m_txbusy) m_out.tx_start = 1'b1;
				end else if (fifo_mode()) begin
					m_txq[m_txp & 15] = v;
					m_txp = (m_txp + 1) & 15;
					if (m_txp != 0) begin
						prev = m_lsr;
						m_lsr = m_lsr & 8'h9f;
						if (prev[5] != m_lsr[5]) rank_ints();
					end else kick_tx();
				end else begin
					m_thr = v;
					kick_tx();
				end
			end
			u16550_pkg::REG_IER: begin
				if (m_lcr[7]) begin
					m_div[15:8] = v;
					if (m_txbusy) m_out.tx_start = 1'b1;
				end else begin
					m_ier = v[3:0];
					rank_ints();
				end
			end
			u16550_pkg::REG_IIR: begin
				if (m_variant == u16550_pkg::VAR_16550) begin
					m_fcr = v & 8'hf9;
					m_fifo_on = v[0];
					if (!v[0]) begin
						foreach (m_rxq[i]) m_rxq[i] = '0;
						foreach (m_txq[i]) m_txq[i] = '0;
						m_rxp = 0; m_txp = 0; m_trig = 1;
					end else begin
						if (v[1]) begin
							foreach (m_rxq[i]) m_rxq[i] = '0;
							m_rxp = 0;
						end
						if (v[2]) begin
							foreach (m_txq[i]) m_txq[i] = '0;
							m_txp = 0;
						end
						case (v[7:6])
							2'd0: m_trig = 1;
							2'd1: m_trig = 4;
							2'd2: m_trig = 8;
							default: m_trig = 14;
						endcase
					end
				end
			end
			u16550_pkg::REG_LCR: begin
				prev = m_lcr;
				m_lcr = v;
				if ((prev[3:0] != v[3:0]) && m_txbusy) m_out.tx_start = 1'b1;
			end
			u16550_pkg::REG_LSR: begin
				m_lsr = v;
				if (v[0]) m_pend[u16550_pkg::PI_RX] = 1'b1;
				if (v[4:1] != 4'd0) m_pend[u16550_pkg::PI_LSR] = 1'b1;
				if (v[5]) m_pend[u16550_pkg::PI_TX] = 1'b1;
				rank_ints();
			end
			u16550_pkg::REG_MSR: begin
				m_msr = v;
				if (v[3:0] != 4'd0) m_pend[u16550_pkg::PI_MSR] = 1'b1;
				rank_ints();
			end
			u16550_pkg::REG_SCR: if (m_variant >= u16550_pkg::VAR_16450) m_scr = v;
			default: ;
		endcase
	endfunction

	// read-side queue advance; empties flag RX done on wrap
	function automatic logic [7:0] pop_slot(ref int pos, input int len, input logic is_tx);
		logic [7:0] r;
		if (is_tx) r = m_txq[pos];
		else r = (pos < u16550_pkg::RX_FIFO_DEPTH) ? m_rxq[pos] : 8'h00;
		pos = (pos + 1) % len;
		if (pos == 0) begin
			m_lsr[0] = 1'b0;
			m_pend[u16550_pkg::PI_RX] = 1'b0;
			rank_ints();
		end
		return r;
	endfunction

	function automatic logic [7:0] reg_read(logic [2:0] a);
		logic [7:0] r;
		r = '0;
		case (a)
			u16550_pkg::REG_DATA: begin
				if (m_lcr[7]) r = m_div[7:0];
				else if (fifo_mode()) begin
					if (m_mcr[4]) r = pop_slot(m_txp, u16550_pkg::TX_FIFO_DEPTH, 1'b1);
					else r = pop_slot(m_rxp, (m_trig != 0) ? m_trig : 1, 1'b0);
				end else begin
					r = m_rbr;
					m_lsr[0] = 1'b0;
					m_pend[u16550_pkg::PI_RX] = 1'b0;
					rank_ints();
				end
			end
			u16550_pkg::REG_IER: r = m_lcr[7] ? m_div[15:8] : {4'h0, m_ier};
			u16550_pkg::REG_IIR: begin
				r = {5'h0, m_iir};
				if (m_iir[2:1] == 2'b01) begin
					m_pend[u16550_pkg::PI_TX] = 1'b0;
					rank_ints();
				end
				if (m_fcr[0]) r = r | 8'hc0;
			end
			u16550_pkg::REG_LCR: r = m_lcr;
			u16550_pkg::REG_MCR: r = m_mcr;
			u16550_pkg::REG_LSR: begin
				if (m_lsr[5]) m_lsr[6] = 1'b1;
				m_lsr[5] = 1'b1;
				r = m_lsr;
				if (m_lsr[4:0] != 5'd0) m_lsr = m_lsr & 8'he1;
				m_pend[u16550_pkg::PI_LSR] = 1'b0;
				rank_ints();
			end
			u16550_pkg::REG_MSR: begin
				r = m_msr;
				m_msr = m_msr & 8'hf0;
				m_pend[u16550_pkg::PI_MSR] = 1'b0;
				rank_ints();
			end
			default: r = m_scr;
		endcase
		return r;
	endfunction

	function automatic u16550_pkg::result_t uart_predict(u16550_pkg::item_t it);
		logic [7:0] nm;
		m_evald = 1'b0; m_ereq = 1'b0;
		m_out = '0;
		case (it.action)
			u16550_pkg::ACT_READ: m_out.read_data = reg_read(it.reg_addr);
			u16550_pkg::ACT_WRITE: begin
				if (it.reg_addr == u16550_pkg::REG_MCR) begin
					if (it.data_in[1] && !m_mcr[1]) m_out.rts_rise = 1'b1;
					m_mcr = it.data_in;
					if (it.data_in[4]) begin
						// loopback: modem lines follow MCR, deltas on change
						nm = {it.data_in[3:2], 6'h0};
						if (it.data_in[1]) nm[4] = 1'b1;
						if (it.data_in[0]) nm[5] = 1'b1;
						if (m_msr[4] != nm[4]) nm[0] = 1'b1;
						if (m_msr[5] != nm[5]) nm[1] = 1'b1;
						if (m_msr[7] != nm[7]) nm[3] = 1'b1;
						if (m_msr[6] && !nm[6]) nm[2] = 1'b1;
						m_msr = nm;
						m_txp = 0; m_rxp = 0;
					end
				end else reg_write(it.reg_addr, it.data_in);
			end
			u16550_pkg::ACT_RXBYTE: line_rx(it.data_in);
			default: begin
				if (m_txbusy) begin
					if (m_fifo_on) begin
						nm = m_txq[m_txp & 15];
						m_txp = (m_txp + 1) & 15;
						line_tx(nm);
						if (m_txp == 0) begin
							m_lsr[6] = 1'b1;
							m_txbusy = 1'b0;
						end
					end else begin
						line_tx(m_thr);
						m_lsr[6] = 1'b1;
						m_txbusy = 1'b0;
					end
				end
			end
		endcase
		m_out.irq_active = (m_variant >= u16550_pkg::VAR_16450) ? m_irq_lvl
			: (m_evald && m_ereq);
		return m_out;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------
	u16550_pkg::result_t pending_results[$];
	int      n_errors = 0;
	logic    gaps_on = 1'b1;

	task automatic report_mismatch(string field, int got, int want);
		$display("[%0t] %s: got %0h, want %0h", $realtime, field, got, want);
		n_errors++;
	endtask

	// result strobe cannot be held off; check every beat as it appears
	always @(posedge clk) begin
		u16550_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected beat", int'(result), 0);
			else begin
				want = pending_results.pop_front();
				if (result.read_data !== want.read_data)
					report_mismatch("read_data", int'(result.read_data),
						int'(want.read_data));
				if (result.irq_active !== want.irq_active)
					report_mismatch("irq_active", int'(result.irq_active),
						int'(want.irq_active));
				if (result.tx_valid !== want.tx_valid)
					report_mismatch("tx_valid", int'(result.tx_valid),
						int'(want.tx_valid));
				if (result.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", int'(result.tx_byte),
						int'(want.tx_byte));
				if (result.tx_start !== want.tx_start)
					report_mismatch("tx_start", int'(result.tx_start),
						int'(want.tx_start));
				if (result.rts_rise !== want.rts_rise)
					report_mismatch("rts_rise", int'(result.rts_rise),
						int'(want.rts_rise));
			end
		end
	end

	// one command beat; start stays high into the next beat unless a gap falls
	task automatic send_beat(u16550_pkg::item_t it, logic typed, u16550_pkg::result_t want);
		u16550_pkg::result_t pred;
		while (gaps_on && $urandom_range(99) < 29) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pred = uart_predict(it);
		pending_results.push_back(typed ? want : pred);
	endtask

	// variant register is only touched with the block drained
	task automatic set_variant(logic [1:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_variant = v;
	endtask

	// weighted random beat: enough FCR enables and THR writes to reach the queues
	function automatic u16550_pkg::item_t pick_beat();
		u16550_pkg::item_t it;
		int sel;
		it.action = 2'($urandom_range(3));
		it.reg_addr = 3'($urandom_range(7));
		it.data_in = 8'($urandom_range(255));
		sel = $urandom_range(99);
		if (sel < 8) begin
			it.action = u16550_pkg::ACT_WRITE; it.reg_addr = u16550_pkg::REG_IIR;
			it.data_in[0] = 1'b1;
		end else if (sel < 25) begin
			it.action = u16550_pkg::ACT_WRITE; it.reg_addr = u16550_pkg::REG_DATA;
		end else if (sel < 42) it.action = u16550_pkg::ACT_TXSLOT;
		else if (sel < 55) begin
			it.action = u16550_pkg::ACT_READ; it.reg_addr = u16550_pkg::REG_DATA;
		end else if (sel < 62) it.action = u16550_pkg::ACT_RXBYTE;
		// keep DLAB mostly clear so the data port stays reachable
		if (it.action == u16550_pkg::ACT_WRITE && it.reg_addr == u16550_pkg::REG_LCR
			&& $urandom_range(3) != 0)
			it.data_in[7] = 1'b0;
		return it;
	endfunction

	localparam int N_DIR = 29;
	typedef struct {
		u16550_pkg::item_t   it;
		logic                typed;
		u16550_pkg::result_t want;
	} dir_row_t;

	dir_row_t dir_rows [N_DIR] = '{
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_LSR,  8'h00}, 1'b1,
			'{read_data: 8'h20, default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_IIR,  8'h00}, 1'b1,
			'{read_data: 8'h01, default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_SCR,  8'h00}, 1'b1, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_LCR,  8'h80}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_DATA, 8'h00}, 1'b1,
			'{read_data: 8'h60, default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_IER,  8'h00}, 1'b1, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_DATA, 8'hff}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_IER,  8'hff}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_DATA, 8'h00}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_LCR,  8'h03}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_IER,  8'h0f}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_MCR,  8'h0a}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_DATA, 8'ha5}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_TXSLOT, u16550_pkg::REG_DATA, 8'h00}, 1'b0, '{default: '0}},
		// idle period
		'{'{u16550_pkg::ACT_TXSLOT, u16550_pkg::REG_SCR,  8'hff}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_RXBYTE, u16550_pkg::REG_DATA, 8'h00}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_RXBYTE, u16550_pkg::REG_SCR,  8'hff}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_DATA, 8'h00}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_IIR,  8'h00}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_LSR,  8'h1f}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_LSR,  8'h00}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_MSR,  8'h0f}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_MSR,  8'h00}, 1'b0, '{default: '0}},
		// dropped on 8250
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_SCR,  8'h55}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_SCR,  8'h00}, 1'b0, '{default: '0}},
		// loopback on
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_MCR,  8'h1f}, 1'b0, '{default: '0}},
		// FCR ignored
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_IIR,  8'hc7}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_READ,   u16550_pkg::REG_MSR,  8'h00}, 1'b0, '{default: '0}},
		'{'{u16550_pkg::ACT_WRITE,  u16550_pkg::REG_MCR,  8'h00}, 1'b0, '{default: '0}}
	};

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [1:0] phase_var [7];
		int beat_no;
		u16550_pkg::item_t fcr_on;
		phase_var = '{u16550_pkg::VAR_16550, u16550_pkg::VAR_8250, u16550_pkg::VAR_16450,
			u16550_pkg::VAR_8250J, u16550_pkg::VAR_16550, u16550_pkg::VAR_16550,
			u16550_pkg::VAR_8250};
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table on the reset part
		for (int i = 0; i < N_DIR; i++)
			send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		// random phases, one per entry of phase_var; gap-free run in phase 3
		beat_no = 0;
		foreach (phase_var[p]) begin
			set_variant(phase_var[p]);
			if (phase_var[p] == u16550_pkg::VAR_16550) begin
				fcr_on = '{u16550_pkg::ACT_WRITE, u16550_pkg::REG_IIR, 8'h07};
				fcr_on.data_in[7:6] = 2'($urandom_range(3));
				send_beat(fcr_on, 1'b0, '0);
			end
			for (int k = 0; k < 72; k++) begin
				gaps_on = !(p == 3);
				send_beat(pick_beat(), 1'b0, '0);
				beat_no++;
			end
		end
		gaps_on = 1'b1;
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/u16550_pkg.sv
src/u16550_queue.sv
src/u16550_core.sv
src/uart_16550_register_model.sv
src/u16550_checker.sv
dv/uart_16550_register_model_tb.sv
